### hdl/tlid_pkg.sv
// Package with the shared types, constants and the reciprocal table of the takeover LED indicator.
package tlid_pkg;

    // Field widths.
    localparam int POS_W     = 16;
    localparam int CNT_W     = 4;
    localparam int LEVEL_W   = 8;
    localparam int DIST_W    = 16;
    localparam int SPACE_W   = POS_W + 1;
    localparam int MAX_LEDS  = 8;
    localparam int LANE_W    = $clog2(MAX_LEDS);
    localparam int TREE_LVL  = $clog2(MAX_LEDS);

    // Brightness division: numerator is brightness range * (travel range - distance), quotient is one level.
    localparam int QUOT_W    = LEVEL_W;
    localparam int NUM_W     = LEVEL_W + DIST_W;

    // Spacing division by (count - 1) through a scaled reciprocal.
    localparam int RECIP_SHIFT = DIST_W + LANE_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = DIST_W + RECIP_W;

    // Pipeline stage numbers.
    localparam int ST_IN     = 0;
    localparam int ST_SPACE  = 1;
    localparam int ST_NUM    = 2;
    localparam int ST_AT     = 3;
    localparam int ST_DIST   = 4;
    localparam int ST_TREE   = 5;
    localparam int DIV_FIRST = 3;
    localparam int ST_OUT    = DIV_FIRST + QUOT_W;
    localparam int NUM_ST    = ST_OUT + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_POS_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRI_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRI_RANGE = 3'd4;

    // Reset values of the registers.
    localparam logic signed [POS_W-1:0] RST_POS_MIN   = 16'sd0;
    localparam logic signed [POS_W-1:0] RST_POS_MAX   = 16'sd1023;
    localparam logic [CNT_W-1:0]        RST_LED_COUNT = 4'd2;
    localparam logic [LEVEL_W-1:0]      RST_BRI_MIN   = 8'd0;
    localparam logic [LEVEL_W-1:0]      RST_BRI_RANGE = 8'd255;

    // One input item.
    typedef struct packed {
        logic                    active;
        logic signed [POS_W-1:0] pos_current;
        logic signed [POS_W-1:0] pos_target;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic               lit;
        logic [2:0]         led_index;
        logic [LEVEL_W-1:0] brightness;
    } out_item_t;

    // Everything an item carries through the pipeline.
    typedef struct packed {
        logic                                     act;
        logic signed [POS_W-1:0]                  target;
        logic [DIST_W-1:0]                        dcur;
        logic [DIST_W-1:0]                        rng;
        logic                                     negd;
        logic [LANE_W-1:0]                        k;
        logic [DIST_W-1:0]                        quo;
        logic signed [SPACE_W-1:0]                sp;
        logic [NUM_W-1:0]                         rem;
        logic [QUOT_W-1:0]                        quot;
        logic [MAX_LEDS-1:0][SPACE_W-1:0]         at;
        logic [MAX_LEDS-1:0][DIST_W-1:0]          gap;
        logic [MAX_LEDS-1:0][LANE_W-1:0]          idx;
        logic [MAX_LEDS-1:0]                      ok;
        logic [LEVEL_W-1:0]                       bright;
    } stage_t;

    // Reciprocal ceil(2^RECIP_SHIFT / k); exact floor division for 16-bit dividends.
    function automatic logic [RECIP_W-1:0] recip(input logic [LANE_W-1:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            3'd1:    r = 20'd524288;
            3'd2:    r = 20'd262144;
            3'd3:    r = 20'd174763;
            3'd4:    r = 20'd131072;
            3'd5:    r = 20'd104858;
            3'd6:    r = 20'd87382;
            3'd7:    r = 20'd74899;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### hdl/takeover_led_indicator_unit.sv
// Top level of the takeover LED indicator: register file and the full item pipeline.
//
//  Channel | Ports                              | Moves
//  --------+------------------------------------+-----------------------------------
//  input   | s_valid, s_ready, s_data           | active flag, current and target
//  result  | m_valid, m_ready, m_data           | lit flag, LED index, brightness
//  config  | cfg_we, cfg_index, cfg_data        | one register write per cycle
//
// One item enters per cycle when no stall holds the pipeline. Three setup stages, the
// 8-step brightness divider (one quotient bit per stage) and the output stage make up
// the pipeline.
// Reset is synchronous on aresetn, clears the stage valid bits and sets the registers to their reset values.
// Each stage holds its item only while the stage behind it is full and stalled, so
// empty stages fill up during a stall and nothing is lost or repeated.
module takeover_led_indicator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tlid_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tlid_pkg::out_item_t                 m_data,
    input  logic                                cfg_we,
    input  logic [tlid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlid_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic signed [tlid_pkg::POS_W-1:0] pos_min_reg;
    logic signed [tlid_pkg::POS_W-1:0] pos_max_reg;
    logic [tlid_pkg::CNT_W-1:0]        led_count_reg;
    logic [tlid_pkg::LEVEL_W-1:0]      bri_min_reg;
    logic [tlid_pkg::LEVEL_W-1:0]      bri_range_reg;

    tlid_pkg::stage_t                  st_reg  [tlid_pkg::NUM_ST];
    tlid_pkg::stage_t                  st_next [tlid_pkg::NUM_ST];
    logic [tlid_pkg::NUM_ST-1:0]       vld_reg;
    logic [tlid_pkg::NUM_ST-1:0]       rdy;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_min_reg   <= tlid_pkg::RST_POS_MIN;
            pos_max_reg   <= tlid_pkg::RST_POS_MAX;
            led_count_reg <= tlid_pkg::RST_LED_COUNT;
            bri_min_reg   <= tlid_pkg::RST_BRI_MIN;
            bri_range_reg <= tlid_pkg::RST_BRI_RANGE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tlid_pkg::REG_POS_MIN:   pos_min_reg   <= cfg_data;
                tlid_pkg::REG_POS_MAX:   pos_max_reg   <= cfg_data;
                tlid_pkg::REG_LED_COUNT: led_count_reg <= cfg_data[tlid_pkg::CNT_W-1:0];
                tlid_pkg::REG_BRI_MIN:   bri_min_reg   <= cfg_data[tlid_pkg::LEVEL_W-1:0];
                tlid_pkg::REG_BRI_RANGE: bri_range_reg <= cfg_data[tlid_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage can load when it is empty or when the stage after it moves on.
    always_comb begin
        rdy[tlid_pkg::NUM_ST-1] = !vld_reg[tlid_pkg::NUM_ST-1] || m_ready;
        for (int s = tlid_pkg::NUM_ST - 2; s >= 0; s--) begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    assign s_ready = rdy[tlid_pkg::ST_IN];
    assign m_valid = vld_reg[tlid_pkg::ST_OUT];

    // Stage logic; each stage starts from a copy of the item in the stage before it.
    always_comb begin
        logic signed [tlid_pkg::SPACE_W-1:0]  cfg_a;
        logic signed [tlid_pkg::SPACE_W-1:0]  cfg_b;
        logic signed [tlid_pkg::SPACE_W-1:0]  cur_a;
        logic signed [tlid_pkg::SPACE_W-1:0]  cur_b;
        logic [tlid_pkg::CNT_W-1:0]           n_eff;
        logic [tlid_pkg::DIST_W-1:0]          clamp_v;
        logic [tlid_pkg::PROD_W-1:0]          prod_v;
        logic [tlid_pkg::SPACE_W-1:0]         sp_v;
        logic [tlid_pkg::NUM_W-1:0]           trial_v;
        logic signed [19:0]                   at_w;
        logic signed [tlid_pkg::SPACE_W:0]    e1;
        logic signed [tlid_pkg::SPACE_W:0]    e2;
        logic                                 take_b;
        logic [tlid_pkg::LEVEL_W:0]           sum_v;
        logic [tlid_pkg::LEVEL_W-1:0]         bsat_v;
        logic [tlid_pkg::LEVEL_W-1:0]         lvl_v;

        // Input stage: range and sign of the travel, distance to target, LED count.
        st_next[tlid_pkg::ST_IN] = '0;
        cfg_a = tlid_pkg::SPACE_W'(pos_max_reg) - tlid_pkg::SPACE_W'(pos_min_reg);
        cfg_b = tlid_pkg::SPACE_W'(pos_min_reg) - tlid_pkg::SPACE_W'(pos_max_reg);
        cur_a = tlid_pkg::SPACE_W'(s_data.pos_target) - tlid_pkg::SPACE_W'(s_data.pos_current);
        cur_b = tlid_pkg::SPACE_W'(s_data.pos_current) - tlid_pkg::SPACE_W'(s_data.pos_target);
        if (led_count_reg < tlid_pkg::CNT_W'(2)) begin
            n_eff = tlid_pkg::CNT_W'(2);
        end else if (led_count_reg > tlid_pkg::CNT_W'(tlid_pkg::MAX_LEDS)) begin
            n_eff = tlid_pkg::CNT_W'(tlid_pkg::MAX_LEDS);
        end else begin
            n_eff = led_count_reg;
        end
        st_next[tlid_pkg::ST_IN].act    = s_data.active;
        st_next[tlid_pkg::ST_IN].target = s_data.pos_target;
        st_next[tlid_pkg::ST_IN].negd   = cfg_a[tlid_pkg::SPACE_W-1];
        st_next[tlid_pkg::ST_IN].rng    = cfg_a[tlid_pkg::SPACE_W-1] ?
                                          cfg_b[tlid_pkg::DIST_W-1:0] :
                                          cfg_a[tlid_pkg::DIST_W-1:0];
        st_next[tlid_pkg::ST_IN].dcur   = cur_a[tlid_pkg::SPACE_W-1] ?
                                          cur_b[tlid_pkg::DIST_W-1:0] :
                                          cur_a[tlid_pkg::DIST_W-1:0];
        st_next[tlid_pkg::ST_IN].k      = tlid_pkg::LANE_W'(n_eff - tlid_pkg::CNT_W'(1));

        clamp_v = '0;
        prod_v  = '0;
        sp_v    = '0;
        trial_v = '0;
        at_w    = '0;
        e1      = '0;
        e2      = '0;
        take_b  = 1'b0;
        sum_v   = '0;
        bsat_v  = '0;
        lvl_v   = '0;

        for (int s = 1; s < tlid_pkg::NUM_ST; s++) begin
            st_next[s] = st_reg[s-1];

            // Clamped distance left to go, and |spacing| by reciprocal multiply.
            if (s == tlid_pkg::ST_SPACE) begin
                clamp_v = (st_reg[s-1].dcur < st_reg[s-1].rng) ?
                          st_reg[s-1].dcur : st_reg[s-1].rng;
                st_next[s].rem = tlid_pkg::NUM_W'(st_reg[s-1].rng - clamp_v);
                prod_v = tlid_pkg::PROD_W'(st_reg[s-1].rng)
                       * tlid_pkg::PROD_W'(tlid_pkg::recip(st_reg[s-1].k));
                st_next[s].quo = prod_v[tlid_pkg::RECIP_SHIFT +: tlid_pkg::DIST_W];
            end

            // Brightness numerator and signed spacing.
            if (s == tlid_pkg::ST_NUM) begin
                st_next[s].rem = tlid_pkg::NUM_W'(st_reg[s-1].rem[tlid_pkg::DIST_W-1:0])
                               * tlid_pkg::NUM_W'(bri_range_reg);
                st_next[s].quot = '0;
                sp_v = tlid_pkg::SPACE_W'(st_reg[s-1].quo);
                st_next[s].sp = st_reg[s-1].negd ? -sp_v : sp_v;
            end

            // Restoring divider, one quotient bit per stage, most significant first.
            if (s >= tlid_pkg::DIV_FIRST && s < tlid_pkg::DIV_FIRST + tlid_pkg::QUOT_W) begin
                trial_v = tlid_pkg::NUM_W'(st_reg[s-1].rng)
                          << (tlid_pkg::QUOT_W - 1 - (s - tlid_pkg::DIV_FIRST));
                if (st_reg[s-1].rem >= trial_v) begin
                    st_next[s].rem = st_reg[s-1].rem - trial_v;
                    st_next[s].quot[tlid_pkg::QUOT_W - 1 - (s - tlid_pkg::DIV_FIRST)] = 1'b1;
                end
            end

            // LED positions, one lane per LED.
            if (s == tlid_pkg::ST_AT) begin
                for (int i = 0; i < tlid_pkg::MAX_LEDS; i++) begin
                    at_w = 20'(pos_min_reg) + 20'(st_reg[s-1].sp) * 20'(i);
                    st_next[s].at[i] = at_w[tlid_pkg::SPACE_W-1:0];
                end
            end

            // Distance from each LED to the target; lanes past the count are masked.
            if (s == tlid_pkg::ST_DIST) begin
                for (int i = 0; i < tlid_pkg::MAX_LEDS; i++) begin
                    e1 = (tlid_pkg::SPACE_W+1)'(st_reg[s-1].target)
                       - (tlid_pkg::SPACE_W+1)'($signed(st_reg[s-1].at[i]));
                    e2 = (tlid_pkg::SPACE_W+1)'($signed(st_reg[s-1].at[i]))
                       - (tlid_pkg::SPACE_W+1)'(st_reg[s-1].target);
                    st_next[s].gap[i] = e1[tlid_pkg::SPACE_W] ?
                                        e2[tlid_pkg::DIST_W-1:0] : e1[tlid_pkg::DIST_W-1:0];
                    st_next[s].idx[i] = tlid_pkg::LANE_W'(i);
                    st_next[s].ok[i]  = (tlid_pkg::LANE_W'(i) <= st_reg[s-1].k);
                end
            end

            // Minimum tree; the lower lane keeps a tie.
            if (s >= tlid_pkg::ST_TREE && s < tlid_pkg::ST_TREE + tlid_pkg::TREE_LVL) begin
                for (int i = 0; i < tlid_pkg::MAX_LEDS; i++) begin
                    if ((i & ((2 << (s - tlid_pkg::ST_TREE)) - 1)) == 0 &&
                        i + (1 << (s - tlid_pkg::ST_TREE)) < tlid_pkg::MAX_LEDS) begin
                        take_b = st_reg[s-1].ok[i + (1 << (s - tlid_pkg::ST_TREE))] &&
                                 (!st_reg[s-1].ok[i] ||
                                  st_reg[s-1].gap[i + (1 << (s - tlid_pkg::ST_TREE))]
                                  < st_reg[s-1].gap[i]);
                        if (take_b) begin
                            st_next[s].gap[i] =
                                st_reg[s-1].gap[i + (1 << (s - tlid_pkg::ST_TREE))];
                            st_next[s].idx[i] =
                                st_reg[s-1].idx[i + (1 << (s - tlid_pkg::ST_TREE))];
                            st_next[s].ok[i] = 1'b1;
                        end
                    end
                end
            end

            // Output stage: saturate the level, use the floor for zero travel and blank an inactive item.
            if (s == tlid_pkg::ST_OUT) begin
                sum_v  = (tlid_pkg::LEVEL_W+1)'(bri_min_reg)
                       + (tlid_pkg::LEVEL_W+1)'(st_reg[s-1].quot);
                bsat_v = sum_v[tlid_pkg::LEVEL_W] ? '1 : sum_v[tlid_pkg::LEVEL_W-1:0];
                lvl_v  = (st_reg[s-1].rng == '0) ? bri_min_reg : bsat_v;
                st_next[s].bright = st_reg[s-1].act ? lvl_v : '0;
                st_next[s].idx[0] = st_reg[s-1].act ? st_reg[s-1].idx[0] : '0;
            end
        end
    end

    // Valid bits travel with the items.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[tlid_pkg::ST_IN]) begin
                vld_reg[tlid_pkg::ST_IN] <= s_valid;
            end
            for (int s = 1; s < tlid_pkg::NUM_ST; s++) begin
                if (rdy[s]) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // Stage data registers.
    always_ff @(posedge aclk) begin
        for (int s = 0; s < tlid_pkg::NUM_ST; s++) begin
            if (rdy[s]) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    // Result item.
    assign m_data.lit        = st_reg[tlid_pkg::ST_OUT].act;
    assign m_data.led_index  = st_reg[tlid_pkg::ST_OUT].idx[0];
    assign m_data.brightness = st_reg[tlid_pkg::ST_OUT].bright;

endmodule

### tb/indicator_checker.sv
// Checker for the takeover LED indicator: tracks register writes, predicts each result and compares.
module indicator_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  tlid_pkg::in_item_t                  s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  tlid_pkg::out_item_t                 m_data,
    input  logic                                cfg_we,
    input  logic [tlid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlid_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  mismatches,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the register file.
    logic signed [tlid_pkg::POS_W-1:0] travel_lo;
    logic signed [tlid_pkg::POS_W-1:0] travel_hi;
    logic [tlid_pkg::CNT_W-1:0]        led_cnt;
    logic [tlid_pkg::LEVEL_W-1:0]      level_floor;
    logic [tlid_pkg::LEVEL_W-1:0]      level_span;

    // Indicator states still owed by the block, oldest first.
    tlid_pkg::out_item_t owed_q[$];

    function automatic longint pos_of(logic [tlid_pkg::POS_W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint gap_of(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Nearest LED and its brightness for one item, at full width.
    function automatic tlid_pkg::out_item_t predict_indicator(tlid_pkg::in_item_t it);
        tlid_pkg::out_item_t res;
        longint    lo;
        longint    hi;
        longint    tgt;
        longint    step;
        longint    best;
        longint    d;
        longint    rng;
        longint    lvl;
        int        n;
        int        pick;
        res = '0;
        if (!it.active) return res;
        lo  = pos_of(travel_lo);
        hi  = pos_of(travel_hi);
        tgt = pos_of(it.pos_target);

        // Out-of-range counts fall back to the nearest legal one.
        n = int'(led_cnt);
        if (n < 2) n = 2;
        if (n > tlid_pkg::MAX_LEDS) n = tlid_pkg::MAX_LEDS;
        step = (hi - lo) / longint'(n - 1);

        // Strict compare keeps the lower index on a tie.
        best = gap_of(tgt, lo);
        pick = 0;
        for (int i = 1; i < n; i++) begin
            d = gap_of(tgt, lo + step * i);
            if (d < best) begin
                best = d;
                pick = i;
            end
        end

        // Brightness ramps over the whole travel and saturates at full scale.
        rng = gap_of(hi, lo);
        d   = gap_of(tgt, pos_of(it.pos_current));
        if (rng == 0) begin
            lvl = longint'(level_floor);
        end else begin
            if (d > rng) d = rng;
            lvl = longint'(level_floor) + (longint'(level_span) * (rng - d)) / rng;
            if (lvl > 255) lvl = 255;
        end
        res.lit        = 1'b1;
        res.led_index  = 3'(pick);
        res.brightness = 8'(lvl);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Watch all three ports at the rising edge.
    always @(posedge aclk) begin : watch
        tlid_pkg::out_item_t want;
        if (!aresetn) begin
            travel_lo   = tlid_pkg::RST_POS_MIN;
            travel_hi   = tlid_pkg::RST_POS_MAX;
            led_cnt     = tlid_pkg::RST_LED_COUNT;
            level_floor = tlid_pkg::RST_BRI_MIN;
            level_span  = tlid_pkg::RST_BRI_RANGE;
            owed_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            // Compare each result item with the oldest prediction.
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    report_mismatch("unexpected result item", longint'(m_data), 0);
                end else begin
                    want = owed_q.pop_front();
                    if (m_data.lit !== want.lit)
                        report_mismatch("lit", longint'(m_data.lit), longint'(want.lit));
                    if (m_data.led_index !== want.led_index)
                        report_mismatch("led_index", longint'(m_data.led_index),
                                        longint'(want.led_index));
                    if (m_data.brightness !== want.brightness)
                        report_mismatch("brightness", longint'(m_data.brightness),
                                        longint'(want.brightness));
                end
            end

            // Predict every accepted input item.
            if (s_valid && s_ready)
                owed_q.push_back(predict_indicator(s_data));

            // Follow register writes; unused indexes have no effect.
            if (cfg_we) begin
                case (cfg_index)
                    tlid_pkg::REG_POS_MIN:   travel_lo   = cfg_data[tlid_pkg::POS_W-1:0];
                    tlid_pkg::REG_POS_MAX:   travel_hi   = cfg_data[tlid_pkg::POS_W-1:0];
                    tlid_pkg::REG_LED_COUNT: led_cnt     = cfg_data[tlid_pkg::CNT_W-1:0];
                    tlid_pkg::REG_BRI_MIN:   level_floor = cfg_data[tlid_pkg::LEVEL_W-1:0];
                    tlid_pkg::REG_BRI_RANGE: level_span  = cfg_data[tlid_pkg::LEVEL_W-1:0];
                    default: ;
                endcase
            end
            outstanding = owed_q.size();
        end
    end

endmodule

### tb/tb_top.sv
// Testbench top for the takeover LED indicator: clock, reset, stimulus and the final verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [tlid_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 60;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    tlid_pkg::in_item_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    tlid_pkg::out_item_t             m_data;
    logic                            cfg_we    = 1'b0;
    logic [tlid_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tlid_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    int                              mismatches;
    int                              outstanding;

    // Stimulus shaping state.
    bit     calm       = 1'b0;
    int     run_left   = 0;
    int     ready_left = 0;
    longint lo_pos     = 0;
    longint hi_pos     = 1023;
    int     leds       = 2;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    takeover_led_indicator_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    indicator_checker u_indicator_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic longint clamp_pos(longint v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    function automatic tlid_pkg::in_item_t sample_of(bit act, longint cur, longint tgt);
        tlid_pkg::in_item_t it;
        it.active      = act;
        it.pos_current = 16'(cur);
        it.pos_target  = 16'(tgt);
        return it;
    endfunction

    // Register write, one cycle of write enable; keeps the local layout copy current.
    task automatic write_reg(logic [tlid_pkg::CFG_IDX_W-1:0] idx,
                             logic [tlid_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            tlid_pkg::REG_POS_MIN:   lo_pos = longint'($signed(data));
            tlid_pkg::REG_POS_MAX:   hi_pos = longint'($signed(data));
            tlid_pkg::REG_LED_COUNT: leds = (data[3:0] < 2) ? 2 :
                                            (data[3:0] > 8) ? 8 : int'(data[3:0]);
            default: ;
        endcase
    endtask

    // Stop sending and wait until every predicted result has come out.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic apply_layout(longint pmin, longint pmax, logic [15:0] cnt_word,
                                logic [15:0] floor_word, logic [15:0] span_word);
        wait_drained();
        write_reg(tlid_pkg::REG_POS_MIN, 16'(pmin));
        write_reg(tlid_pkg::REG_POS_MAX, 16'(pmax));
        write_reg(tlid_pkg::REG_LED_COUNT, cnt_word);
        write_reg(tlid_pkg::REG_BRI_MIN, floor_word);
        write_reg(tlid_pkg::REG_BRI_RANGE, span_word);
    endtask

    // Offer one item after an optional idle burst and hold it until it is taken.
    task automatic feed(tlid_pkg::in_item_t it);
        int gap = 0;
        if (!calm) begin
            if (run_left > 0) run_left--;
            else if ($urandom_range(0, 24) == 0) run_left = $urandom_range(15, 40);
            else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 8);
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Targets are random or cluster on LEDs, on midpoints between them and at the ends of travel.
    function automatic longint random_position();
        longint step;
        longint v;
        step = (hi_pos - lo_pos) / (leds - 1);
        case ($urandom_range(0, 3))
            0: v = longint'($signed(16'($urandom)));
            1: v = lo_pos + step * int'($urandom_range(0, leds - 1))
                   + int'($urandom_range(0, 6)) - 3;
            2: v = lo_pos + step * int'($urandom_range(0, leds - 2)) + step / 2
                   + int'($urandom_range(0, 2)) - 1;
            default: v = ($urandom_range(0, 1) ? hi_pos : lo_pos)
                         + int'($urandom_range(0, 8)) - 4;
        endcase
        return clamp_pos(v);
    endfunction

    function automatic tlid_pkg::in_item_t random_sample();
        longint tgt;
        longint cur;
        longint span;
        tgt  = random_position();
        span = ((hi_pos > lo_pos) ? hi_pos - lo_pos : lo_pos - hi_pos) + 1;
        case ($urandom_range(0, 2))
            0: cur = longint'($signed(16'($urandom)));
            1: cur = tgt + longint'($urandom_range(0, 2 * span)) - span;
            default: cur = tgt + int'($urandom_range(0, 6)) - 3;
        endcase
        return sample_of($urandom_range(0, 4) != 0, clamp_pos(cur), tgt);
    endfunction

    // New register setting: random, full-width or reversed, narrow, mid-sized or zero travel.
    task automatic shuffle_layout();
        longint      pmin;
        longint      pmax;
        logic [15:0] cw;
        logic [15:0] fw;
        logic [15:0] sw;
        pmin = longint'($signed(16'($urandom)));
        case ($urandom_range(0, 4))
            0: pmax = longint'($signed(16'($urandom)));
            1: begin
                pmin = -32768;
                pmax = 32767;
                if ($urandom_range(0, 1)) begin
                    pmin = 32767;
                    pmax = -32768;
                end
            end
            2: pmax = clamp_pos(pmin + int'($urandom_range(0, 80)) - 40);
            3: pmax = pmin;
            default: pmax = clamp_pos(pmin + int'($urandom_range(0, 4000)) - 2000);
        endcase
        cw = 16'($urandom);
        if ($urandom_range(0, 3) != 0) cw[3:0] = 4'($urandom_range(2, 8));
        fw = 16'($urandom);
        case ($urandom_range(0, 3))
            1: fw[7:0] = 8'h00;
            2: fw[7:0] = 8'hFF;
            default: ;
        endcase
        sw = 16'($urandom);
        case ($urandom_range(0, 3))
            1: sw[7:0] = 8'h00;
            2: sw[7:0] = 8'hFF;
            default: ;
        endcase
        apply_layout(pmin, pmax, cw, fw, sw);
    endtask

    // Result side: ready alternates between ready runs and stall bursts, and stays high in the calm phase.
    initial begin
        forever begin
            @(negedge aclk);
            if (calm) begin
                m_ready <= 1'b1;
            end else if (ready_left != 0) begin
                ready_left--;
            end else if (m_ready) begin
                m_ready    <= 1'b0;
                ready_left = $urandom_range(0, 7);
            end else begin
                m_ready    <= 1'b1;
                ready_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 10);
            end
        end
    end

    // Main sequence: reset, directed cases, random phases, drain, verdict.
    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset layout: inactive items, both ends of travel, distance beyond the range.
        feed(sample_of(1'b0, -32768, 32767));
        feed(sample_of(1'b0, -1, -1));
        feed(sample_of(1'b1, 0, 0));
        feed(sample_of(1'b1, 0, 1023));
        feed(sample_of(1'b1, 511, 512));
        feed(sample_of(1'b1, -32768, 32767));
        feed(sample_of(1'b1, 32767, -32768));

        // Full travel with eight LEDs; a target halfway between the first two ties.
        apply_layout(-32768, 32767, 16'd8, 16'd0, 16'd255);
        feed(sample_of(1'b1, -32768 + 4681, -32768 + 4681));
        feed(sample_of(1'b1, -32768, 32767));
        feed(sample_of(1'b1, 1, 0));

        // Reversed travel gives a negative spacing.
        apply_layout(32767, -32768, 16'd7, 16'd0, 16'd255);
        feed(sample_of(1'b1, 0, -32768));
        feed(sample_of(1'b1, 32767 - 5461, 32767 - 5461));

        // Zero travel: brightness stays at its floor.
        apply_layout(100, 100, 16'd5, 16'd200, 16'd255);
        feed(sample_of(1'b1, 100, 100));
        feed(sample_of(1'b1, 32767, -32768));

        // Counts below two, saturated brightness, ties between LEDs.
        apply_layout(0, 8, 16'd0, 16'd255, 16'd255);
        feed(sample_of(1'b1, 4, 4));
        wait_drained();
        write_reg(tlid_pkg::REG_LED_COUNT, 16'd1);
        feed(sample_of(1'b1, 0, 8));
        wait_drained();
        write_reg(tlid_pkg::REG_LED_COUNT, 16'd3);
        write_reg(tlid_pkg::REG_BRI_MIN, 16'd100);
        write_reg(tlid_pkg::REG_BRI_RANGE, 16'd200);
        feed(sample_of(1'b1, 2, 2));
        feed(sample_of(1'b1, 8, 6));

        // Count above the LED limit, then a write to an unused index.
        wait_drained();
        write_reg(tlid_pkg::REG_LED_COUNT, 16'hFFFF);
        feed(sample_of(1'b1, 100, 8));
        wait_drained();
        write_reg(REG_UNUSED, 16'hFFFF);
        feed(sample_of(1'b1, 3, 3));

        // Random phases, each with its own register setting; the last one runs without idling.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES - 1) calm = 1'b1;
            shuffle_layout();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (!calm && $urandom_range(0, 59) == 0) wait_drained();
                feed(random_sample());
            end
        end

        wait_drained();
        repeat (30) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
